@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/itmm_pkg.sv @@
// types and constants of the interval throughput min/max meter
package itmm_pkg;

	localparam int TS_W        = 64;
	localparam int BC_W        = 32;
	localparam int CFG_W       = 12;
	localparam int OUT_W       = 48;
	localparam int LEN_W       = 42;
	localparam int KDEN_W      = 22;
	localparam int Q_SHIFT     = 11;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [29:0]       NS_PER_SEC = 30'd1000000000;
	localparam logic [9:0]        K_PER_SEC  = 10'd1000;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 42'd1000000000;
	localparam logic [KDEN_W-1:0] KDEN_RESET = 22'd1000;

	typedef struct packed {
		logic [TS_W-1:0] timestamp_ns;
		logic [BC_W-1:0] byte_count;
	} item_t;

endpackage

@@ rtl/itmm_queue.sv @@
// input front: accepts transactions into a short queue for the back end
module itmm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  itmm_pkg::item_t in_item,
	output logic            deq_valid,
	input  logic            deq_ready,
	output itmm_pkg::item_t deq_item
);

	localparam int PTR_W = (itmm_pkg::QUEUE_DEPTH > 1) ? $clog2(itmm_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(itmm_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(itmm_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(itmm_pkg::QUEUE_DEPTH);

	itmm_pkg::item_t  mem_q [itmm_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != CNT_FULL);
	assign deq_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = deq_valid && deq_ready;
	assign deq_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

@@ rtl/itmm_divider.sv @@
// shared restoring divider, one quotient bit per cycle
module itmm_divider #(
	parameter int NUM_W,
	parameter int DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             take;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign take  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

@@ rtl/itmm_back.sv @@
// back end: interval bookkeeping, min/max tracking, rate scaling and result register
module itmm_back #(
	parameter int ACC_W,
	parameter int NUM_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [itmm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           deq_valid,
	output logic                           deq_ready,
	input  itmm_pkg::item_t                deq_item,
	output logic                           div_start,
	output logic [NUM_W-1:0]               div_num,
	output logic [itmm_pkg::LEN_W-1:0]     div_den,
	input  logic                           div_done,
	input  logic [NUM_W-1:0]               div_quot,
	input  logic [itmm_pkg::LEN_W-1:0]     div_rem,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [itmm_pkg::OUT_W-1:0]     min_kbps_q8,
	output logic [itmm_pkg::OUT_W-1:0]     max_kbps_q8,
	output logic                           range_valid
);

	localparam int TS_W  = itmm_pkg::TS_W;
	localparam int LEN_W = itmm_pkg::LEN_W;
	localparam int OUT_W = itmm_pkg::OUT_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CALC  = 4'd1;
	localparam logic [3:0] ST_CLASS = 4'd2;
	localparam logic [3:0] ST_LINT  = 4'd3;
	localparam logic [3:0] ST_WINT  = 4'd4;
	localparam logic [3:0] ST_LMIN  = 4'd5;
	localparam logic [3:0] ST_WMIN  = 4'd6;
	localparam logic [3:0] ST_LMAX  = 4'd7;
	localparam logic [3:0] ST_WMAX  = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	logic [3:0]                    state_q;
	logic [TS_W-1:0]               ts_q;
	logic [itmm_pkg::BC_W-1:0]     bc_q;
	logic [TS_W-1:0]               delta_q;
	logic                          before_q;
	logic                          started_q;
	logic [TS_W-1:0]               start_q;
	logic [ACC_W-1:0]              total_q;
	logic [ACC_W-1:0]              min_q;
	logic [ACC_W-1:0]              max_q;
	logic                          have_q;
	logic [LEN_W-1:0]              len_q;
	logic [itmm_pkg::KDEN_W-1:0]   kden_q;
	logic                          dirty_q;
	logic [OUT_W-1:0]              min_kbps_q;
	logic [OUT_W-1:0]              max_kbps_q;
	logic                          out_valid_q;
	logic [OUT_W-1:0]              out_min_q;
	logic [OUT_W-1:0]              out_max_q;
	logic                          out_range_q;

	logic [itmm_pkg::CFG_W-1:0]    sec;
	logic [TS_W:0]                 delta_ext;
	logic [ACC_W:0]                sum;
	logic [ACC_W-1:0]              total_sat;
	logic                          skip2;
	logic [ACC_W-1:0]              close_min;
	logic [ACC_W-1:0]              close_max;
	logic [OUT_W-1:0]              quot_sat;
	logic                          emit_ok;
	logic                          emit_fire;
	logic [3:0]                    after_state;

	assign sec       = (cfg_wdata == '0) ? itmm_pkg::CFG_W'(1) : cfg_wdata;
	assign delta_ext = {1'b0, ts_q} - {1'b0, start_q};
	assign sum       = {1'b0, total_q} + (ACC_W + 1)'(bc_q);
	assign total_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
	assign skip2     = |div_quot[NUM_W-1:1];
	assign quot_sat  = (|div_quot[NUM_W-1:OUT_W]) ? '1 : div_quot[OUT_W-1:0];
	assign emit_ok   = !out_valid_q || out_ready;
	assign emit_fire = (state_q == ST_EMIT) && emit_ok;
	assign after_state = (have_q && dirty_q) ? ST_LMIN : ST_EMIT;

	always_comb begin
		if (!have_q) begin
			close_min = total_q;
			close_max = total_q;
		end else begin
			close_min = (total_q < min_q) ? total_q : min_q;
			close_max = (total_q > max_q) ? total_q : max_q;
		end
		if (skip2) begin
			close_min = '0;
		end
	end

	assign deq_ready = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_LINT) || (state_q == ST_LMIN) || (state_q == ST_LMAX);

	always_comb begin
		case (state_q)
			ST_LINT: begin
				div_num = NUM_W'(delta_q);
				div_den = len_q;
			end
			ST_LMIN: begin
				div_num = NUM_W'({min_q, {itmm_pkg::Q_SHIFT{1'b0}}});
				div_den = LEN_W'(kden_q);
			end
			ST_LMAX: begin
				div_num = NUM_W'({max_q, {itmm_pkg::Q_SHIFT{1'b0}}});
				div_den = LEN_W'(kden_q);
			end
			default: begin
				div_num = '0;
				div_den = len_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			have_q      <= 1'b0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			len_q       <= itmm_pkg::LEN_RESET;
			kden_q      <= itmm_pkg::KDEN_RESET;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (deq_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					if (!started_q) begin
						started_q <= 1'b1;
						state_q   <= after_state;
					end else if (before_q || delta_q < TS_W'(len_q)) begin
						state_q <= after_state;
					end else begin
						state_q <= ST_LINT;
					end
				end
				ST_LINT: begin
					state_q <= ST_WINT;
				end
				ST_WINT: begin
					if (div_done) begin
						have_q  <= 1'b1;
						state_q <= ST_LMIN;
					end
				end
				ST_LMIN: begin
					state_q <= ST_WMIN;
				end
				ST_WMIN: begin
					if (div_done) begin
						state_q <= ST_LMAX;
					end
				end
				ST_LMAX: begin
					state_q <= ST_WMAX;
				end
				ST_WMAX: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				len_q   <= LEN_W'(sec) * LEN_W'(itmm_pkg::NS_PER_SEC);
				kden_q  <= itmm_pkg::KDEN_W'(sec) * itmm_pkg::KDEN_W'(itmm_pkg::K_PER_SEC);
				dirty_q <= 1'b1;
			end else if (state_q == ST_LMIN) begin
				dirty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (deq_valid) begin
					ts_q <= deq_item.timestamp_ns;
					bc_q <= deq_item.byte_count;
				end
			end
			ST_CALC: begin
				delta_q  <= delta_ext[TS_W-1:0];
				before_q <= delta_ext[TS_W];
			end
			ST_CLASS: begin
				if (!started_q) begin
					start_q <= ts_q;
					total_q <= ACC_W'(bc_q);
				end else if (before_q || delta_q < TS_W'(len_q)) begin
					total_q <= total_sat;
				end
			end
			ST_WINT: begin
				if (div_done) begin
					min_q   <= close_min;
					max_q   <= close_max;
					start_q <= ts_q - TS_W'(div_rem);
					total_q <= ACC_W'(bc_q);
				end
			end
			ST_WMIN: begin
				if (div_done) begin
					min_kbps_q <= quot_sat;
				end
			end
			ST_WMAX: begin
				if (div_done) begin
					max_kbps_q <= quot_sat;
				end
			end
			ST_EMIT: begin
				if (emit_ok) begin
					out_min_q   <= have_q ? min_kbps_q : '0;
					out_max_q   <= have_q ? max_kbps_q : '0;
					out_range_q <= have_q;
				end
			end
			default: begin
				ts_q <= ts_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign min_kbps_q8 = out_min_q;
	assign max_kbps_q8 = out_max_q;
	assign range_valid = out_range_q;

endmodule

@@ rtl/interval_throughput_min_max.sv @@
// top level of the interval throughput min/max meter
//
// Input channel (in_valid/in_ready): one transaction per event, timestamp_ns and
// byte_count. Output channel (out_valid/out_ready): exactly one transaction per
// event with min_kbps_q8, max_kbps_q8 (kbit/s, 8 fraction bits) and range_valid.
// cfg_we/cfg_wdata write the interval length in seconds (0 acts as 1); write it
// only while no event is in flight. It takes effect from the next event on.
// An event inside the current interval passes the states CALC, CLASS and EMIT
// before out_valid rises. An event that closes an interval also waits on the
// divider three times, and the first event after a length change once a range
// exists, if it closes no interval, twice. The one shared bit-serial divider,
// NUM_W = max(64, BYTE_ACC_BITS + 11) bits wide, finds the whole intervals
// skipped, then scales the minimum and then the maximum byte total.
// The back end takes no new event until its result is in the output register.
// A two-entry queue takes new events while the back end works or while a result
// waits in the output register; a stalled receiver holds the result steady and
// fills the queue, after which in_ready drops. Reset clears the queue, the
// interval state and the range, and sets the length to one second.
module interval_throughput_min_max #(
	parameter int BYTE_ACC_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [itmm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [itmm_pkg::TS_W-1:0]      timestamp_ns,
	input  logic [itmm_pkg::BC_W-1:0]      byte_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [itmm_pkg::OUT_W-1:0]     min_kbps_q8,
	output logic [itmm_pkg::OUT_W-1:0]     max_kbps_q8,
	output logic                           range_valid
);

	localparam int NUM_W = (BYTE_ACC_BITS + itmm_pkg::Q_SHIFT > itmm_pkg::TS_W) ?
		BYTE_ACC_BITS + itmm_pkg::Q_SHIFT : itmm_pkg::TS_W;

	itmm_pkg::item_t               in_item;
	itmm_pkg::item_t               deq_item;
	logic                          deq_valid;
	logic                          deq_ready;
	logic                          div_start;
	logic [NUM_W-1:0]              div_num;
	logic [itmm_pkg::LEN_W-1:0]    div_den;
	logic                          div_done;
	logic [NUM_W-1:0]              div_quot;
	logic [itmm_pkg::LEN_W-1:0]    div_rem;

	assign in_item.timestamp_ns = timestamp_ns;
	assign in_item.byte_count   = byte_count;

	itmm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_item  (deq_item)
	);

	itmm_divider #(
		.NUM_W (NUM_W),
		.DEN_W (itmm_pkg::LEN_W)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	itmm_back #(
		.ACC_W (BYTE_ACC_BITS),
		.NUM_W (NUM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.deq_valid   (deq_valid),
		.deq_ready   (deq_ready),
		.deq_item    (deq_item),
		.div_start   (div_start),
		.div_num     (div_num),
		.div_den     (div_den),
		.div_done    (div_done),
		.div_quot    (div_quot),
		.div_rem     (div_rem),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.min_kbps_q8 (min_kbps_q8),
		.max_kbps_q8 (max_kbps_q8),
		.range_valid (range_valid)
	);

endmodule

@@ rtl/itmm_checker.sv @@
// port-level checker for the interval throughput meter, bound to the top level
`include "assert_macros.svh"

module itmm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [itmm_pkg::OUT_W-1:0] min_kbps_q8,
	input logic [itmm_pkg::OUT_W-1:0] max_kbps_q8,
	input logic                       range_valid
);

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(min_kbps_q8) && $stable(max_kbps_q8) && $stable(range_valid), "result transaction changed while stalled")
	`ASSERT_NOW(a_empty_zero, out_valid && !range_valid, min_kbps_q8 == '0 && max_kbps_q8 == '0, "nonzero rate without a closed interval")
	`ASSERT_NOW(a_min_le_max, out_valid && range_valid, min_kbps_q8 <= max_kbps_q8, "minimum rate above maximum rate")
	`ASSERT_NEXT(a_range_sticky, out_valid && range_valid, !out_valid || range_valid, "range_valid dropped after an interval closed")

endmodule

bind interval_throughput_min_max itmm_checker u_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// testbench of the interval throughput min/max meter: directed and random events
module tb_top;

	localparam int          TS_W           = itmm_pkg::TS_W;
	localparam int          BC_W           = itmm_pkg::BC_W;
	localparam int          CFG_W          = itmm_pkg::CFG_W;
	localparam int          OUT_W          = itmm_pkg::OUT_W;
	localparam int          Q_SHIFT        = itmm_pkg::Q_SHIFT;
	localparam int          CLK_HALF       = 5;
	localparam int          RESET_CYCLES   = 8;
	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          TAIL_CYCLES    = 250;
	localparam int          BURST_EVENTS   = 16;
	localparam int          RANDOM_EVENTS  = 335;
	localparam logic [63:0] ONE_SEC_NS     = 64'd1_000_000_000;
	localparam logic [63:0] KBIT_DIV       = 64'd1000;
	localparam logic [63:0] BYTE_SUM_MAX   = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] RATE_MAX       = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] RATE_WHOLE_LIM = 64'd1 << 37;

	typedef struct packed {
		logic [OUT_W-1:0] min_q8;
		logic [OUT_W-1:0] max_q8;
		logic             range_ok;
	} rate_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [TS_W-1:0]  timestamp_ns = '0;
	logic [BC_W-1:0]  byte_count = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [OUT_W-1:0] min_kbps_q8;
	logic [OUT_W-1:0] max_kbps_q8;
	logic             range_valid;

	// predictor state
	logic [CFG_W-1:0] ivl_secs = 12'd1;
	bit               ivl_open = 1'b0;
	logic [63:0]      ivl_start = '0;
	logic [63:0]      byte_sum = '0;
	logic [63:0]      low_bytes = '0;
	logic [63:0]      high_bytes = '0;
	bit               have_closed = 1'b0;
	logic [63:0]      latest_ts = '0;

	rate_t rate_q[$];
	rate_t head_rate;
	int    snd_idle_pct = 0;
	int    rcv_idle_pct = 0;
	int    fail_cnt = 0;
	int    quiet_cycles = 0;

	interval_throughput_min_max uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.timestamp_ns (timestamp_ns),
		.byte_count   (byte_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.min_kbps_q8  (min_kbps_q8),
		.max_kbps_q8  (max_kbps_q8),
		.range_valid  (range_valid)
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic [63:0] secs_eff();
		return (ivl_secs == '0) ? 64'd1 : 64'(ivl_secs);
	endfunction

	function automatic logic [63:0] ivl_len();
		return secs_eff() * ONE_SEC_NS;
	endfunction

	function automatic logic [OUT_W-1:0] bytes_to_kbps_q8(input logic [63:0] bytes);
		logic [63:0] den;
		logic [63:0] whole;
		logic [63:0] rem;
		logic [63:0] q;
		den = secs_eff() * KBIT_DIV;
		whole = bytes / den;
		rem = bytes % den;
		if (whole >= RATE_WHOLE_LIM)
			return RATE_MAX[OUT_W-1:0];
		q = (whole << Q_SHIFT) + ((rem << Q_SHIFT) / den);
		return (q > RATE_MAX) ? RATE_MAX[OUT_W-1:0] : q[OUT_W-1:0];
	endfunction

	function automatic void record_interval(input logic [63:0] total);
		if (!have_closed) begin
			low_bytes = total;
			high_bytes = total;
			have_closed = 1'b1;
		end else begin
			if (total < low_bytes)
				low_bytes = total;
			if (total > high_bytes)
				high_bytes = total;
		end
	endfunction

	function automatic rate_t meter_step(input logic [TS_W-1:0] ts,
		input logic [BC_W-1:0] bc);
		logic [63:0] len;
		logic [63:0] skipped;
		logic [63:0] sum;
		rate_t       r;
		len = ivl_len();
		if (!ivl_open) begin
			ivl_open = 1'b1;
			ivl_start = ts;
			byte_sum = 64'(bc);
		end else if (ts < ivl_start || ts - ivl_start < len) begin
			sum = byte_sum + 64'(bc);
			byte_sum = (sum > BYTE_SUM_MAX) ? BYTE_SUM_MAX : sum;
		end else begin
			skipped = (ts - ivl_start) / len;
			record_interval(byte_sum);
			if (skipped >= 64'd2)
				record_interval('0);
			ivl_start += skipped * len;
			byte_sum = 64'(bc);
		end
		r.range_ok = have_closed;
		r.min_q8 = have_closed ? bytes_to_kbps_q8(low_bytes) : '0;
		r.max_q8 = have_closed ? bytes_to_kbps_q8(high_bytes) : '0;
		return r;
	endfunction

	function automatic logic [63:0] rand_below(input logic [63:0] bound);
		return {$urandom, $urandom} % bound;
	endfunction

	function automatic logic [BC_W-1:0] rand_bytes();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return BC_W'($urandom_range(1500));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_secs();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return CFG_W'($urandom_range(4095, 1));
			default: return CFG_W'($urandom_range(6, 1));
		endcase
	endfunction

	// mostly well-ordered time: steps inside, edge hits, skips; some late and stray stamps
	function automatic logic [TS_W-1:0] rand_timestamp();
		logic [63:0] len;
		logic [63:0] base;
		int          pick;
		len = ivl_len();
		base = (latest_ts > ivl_start) ? latest_ts : ivl_start;
		pick = $urandom_range(99);
		if (pick < 55)
			return base + rand_below(len >> 2);
		if (pick < 68)
			return ivl_start + len + 64'($urandom_range(3));
		if (pick < 76)
			return ivl_start + len - 64'd1;
		if (pick < 88)
			return ivl_start + len * 64'($urandom_range(5, 2)) + rand_below(len);
		if (pick < 95)
			return (ivl_start > 64'd1_000_000) ?
				ivl_start - 64'($urandom_range(1_000_000, 1)) : '0;
		return 64'({4'($urandom_range(15)), $urandom});
	endfunction

	task automatic send_event(input logic [TS_W-1:0] ts, input logic [BC_W-1:0] bc);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		timestamp_ns <= ts;
		byte_count <= bc;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		rate_q.push_back(meter_step(ts, bc));
		if (ts > latest_ts)
			latest_ts = ts;
		@(negedge clk);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(negedge clk); while (rate_q.size() != 0);
	endtask

	task automatic set_interval(input logic [CFG_W-1:0] secs);
		wait_results_done();
		cfg_wdata <= secs;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		ivl_secs = secs;
	endtask

	task automatic test_first_interval();
		send_event(64'd5_000_000_000, '0);
		send_event(ivl_start + 64'd1, '1);
		send_event(ivl_start - ONE_SEC_NS, 32'd1000);
		send_event('0, 32'd1);
		send_event(ivl_start + ivl_len() - 64'd1, 32'd7);
	endtask

	task automatic test_interval_close();
		send_event(ivl_start + ivl_len(), 32'd500);
		send_event(ivl_start + 64'd200_000_000, 32'd250);
		send_event(ivl_start + 3 * ivl_len() + 64'd500_000_000, 32'd3);
		send_event(ivl_start + 64'd1, '0);
	endtask

	task automatic test_interval_length();
		set_interval('0);
		send_event(ivl_start + ivl_len(), 32'd100);
		set_interval('1);
		send_event(ivl_start + 64'd5, '1);
		send_event(ivl_start + ivl_len(), 32'd1);
		set_interval(12'hAAA);
		send_event(ivl_start + 2 * ivl_len() + 64'd3, 32'd9);
		set_interval(12'h555);
		send_event(ivl_start + ivl_len() + 64'd1, 32'h5555_5555);
		set_interval(12'd1);
		send_event(ivl_start + ivl_len(), 32'hAAAA_AAAA);
	endtask

	task automatic test_peak_rate();
		repeat (3) send_event(ivl_start + 64'd10, '1);
		send_event(ivl_start + ivl_len(), '0);
		send_event(ivl_start + ivl_len(), '0);
	endtask

	task automatic test_random_traffic(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 99)
				set_interval(rand_secs());
			else if ($urandom_range(39) == 0)
				wait_results_done();
			send_event(rand_timestamp(), rand_bytes());
		end
	endtask

	// a run of maximal byte counts piles up in one interval
	task automatic test_full_bursts();
		set_interval(12'd1);
		send_event(ivl_start + ivl_len(), '1);
		repeat (BURST_EVENTS) send_event(ivl_start + 64'd1, '1);
		send_event(ivl_start + ivl_len(), '0);
	endtask

	task automatic test_timestamp_top();
		send_event('1, 32'h8000_0001);
		send_event('1, 32'd1);
		send_event('0, 32'h7FFF_FFFE);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (rate_q.size() == 0) begin
				$error("unexpected transaction: min_kbps_q8 %0d max_kbps_q8 %0d range_valid %0b",
					min_kbps_q8, max_kbps_q8, range_valid);
				fail_cnt++;
			end else begin
				head_rate = rate_q.pop_front();
				if (min_kbps_q8 !== head_rate.min_q8) begin
					$error("min_kbps_q8: expected %0d, actual %0d", head_rate.min_q8, min_kbps_q8);
					fail_cnt++;
				end
				if (max_kbps_q8 !== head_rate.max_q8) begin
					$error("max_kbps_q8: expected %0d, actual %0d", head_rate.max_q8, max_kbps_q8);
					fail_cnt++;
				end
				if (range_valid !== head_rate.range_ok) begin
					$error("range_valid: expected %0b, actual %0b", head_rate.range_ok, range_valid);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		snd_idle_pct = 38;
		rcv_idle_pct = 63;
		test_first_interval();
		test_interval_close();
		test_interval_length();
		test_peak_rate();
		test_random_traffic(RANDOM_EVENTS);
		snd_idle_pct = 63;
		rcv_idle_pct = 38;
		set_interval(rand_secs());
		test_random_traffic(RANDOM_EVENTS);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_interval(rand_secs());
		test_random_traffic(RANDOM_EVENTS);
		test_full_bursts();
		test_timestamp_top();
		wait_results_done();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
